[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL of the current regulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

[rtl/pidc_pkg.sv]
// Shared types, widths and constants of the PID current regulator.
package pidc_pkg;

    localparam int ADC_BITS       = 12;
    localparam int FRAC_BITS      = 16;
    localparam int DAC_FULL_SCALE = 255;

    localparam int GAIN_W     = 24;
    localparam int DRIVE_W    = 18;
    localparam int DAC_W      = 9;
    localparam int ERR_W      = ADC_BITS + 1;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT  = 3'd0,
        REG_KP_GAIN   = 3'd1,
        REG_KI_GAIN   = 3'd2,
        REG_KD_GAIN   = 3'd3,
        REG_DRIVE_MIN = 3'd4,
        REG_DRIVE_MAX = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic        [ADC_BITS-1:0] setpoint_code;
        logic signed [GAIN_W-1:0]   kp_gain;
        logic signed [GAIN_W-1:0]   ki_gain;
        logic signed [GAIN_W-1:0]   kd_gain;
        logic signed [DRIVE_W-1:0]  drive_min;
        logic signed [DRIVE_W-1:0]  drive_max;
    } pidc_cfg_t;

    localparam logic        [ADC_BITS-1:0] SETPOINT_RESET  = 12'd696;
    localparam logic signed [GAIN_W-1:0]   KP_RESET        = 24'sd3277;
    localparam logic signed [GAIN_W-1:0]   KI_RESET        = 24'sd131;
    localparam logic signed [GAIN_W-1:0]   KD_RESET        = 24'sd0;
    localparam logic signed [DRIVE_W-1:0]  DRIVE_MIN_RESET = -18'sd15401;
    localparam logic signed [DRIVE_W-1:0]  DRIVE_MAX_RESET = 18'sd15401;

endpackage

[rtl/pidc_cfg_regs.sv]
// Configuration register file: setpoint, gains and drive bounds.
module pidc_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output pidc_pkg::pidc_cfg_t               cfg
);
    import pidc_pkg::*;

    pidc_cfg_t cfg_reg;
    pidc_cfg_t cfg_next;

    // Decode the write; indexes past the list are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_SETPOINT:  cfg_next.setpoint_code = cfg_data[ADC_BITS-1:0];
                REG_KP_GAIN:   cfg_next.kp_gain       = $signed(cfg_data[GAIN_W-1:0]);
                REG_KI_GAIN:   cfg_next.ki_gain       = $signed(cfg_data[GAIN_W-1:0]);
                REG_KD_GAIN:   cfg_next.kd_gain       = $signed(cfg_data[GAIN_W-1:0]);
                REG_DRIVE_MIN: cfg_next.drive_min     = $signed(cfg_data[DRIVE_W-1:0]);
                REG_DRIVE_MAX: cfg_next.drive_max     = $signed(cfg_data[DRIVE_W-1:0]);
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.setpoint_code <= SETPOINT_RESET;
            cfg_reg.kp_gain       <= KP_RESET;
            cfg_reg.ki_gain       <= KI_RESET;
            cfg_reg.kd_gain       <= KD_RESET;
            cfg_reg.drive_min     <= DRIVE_MIN_RESET;
            cfg_reg.drive_max     <= DRIVE_MAX_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

endmodule

[rtl/pidc_error_stage.sv]
// Input register, error, saturating error sum and error difference.
module pidc_error_stage #(
    parameter int SUM_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [pidc_pkg::ADC_BITS-1:0]       s_adc_code,
    input  logic [pidc_pkg::ADC_BITS-1:0]       setpoint_code,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [pidc_pkg::ERR_W-1:0]   out_err,
    output logic signed [pidc_pkg::DIFF_W-1:0]  out_diff,
    output logic signed [SUM_WIDTH-1:0]         out_sum
);
    import pidc_pkg::*;

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    logic                        in_valid_reg, in_valid_next;
    logic [ADC_BITS-1:0]         adc_reg, adc_next;
    logic                        out_valid_reg, out_valid_next;
    logic signed [ERR_W-1:0]     err_reg, err_next;
    logic signed [DIFF_W-1:0]    diff_reg, diff_next;
    logic signed [SUM_WIDTH-1:0] sum_reg, sum_next;
    logic signed [SUM_WIDTH-1:0] error_sum_reg, error_sum_next;
    logic signed [ERR_W-1:0]     prev_err_reg, prev_err_next;

    logic                        adv_in, adv_out;
    logic signed [ERR_W-1:0]     err;
    logic signed [SUM_WIDTH:0]   sum_wide;
    logic signed [SUM_WIDTH-1:0] sum_sat;

    // Stage enables: a stage loads when empty or when its item moves on
    assign adv_out = !out_valid_reg || out_ready;
    assign adv_in  = !in_valid_reg || adv_out;
    assign s_ready = adv_in;

    // Error and saturating integration
    assign err      = $signed({1'b0, setpoint_code}) - $signed({1'b0, adc_reg});
    assign sum_wide = (SUM_WIDTH+1)'(error_sum_reg) + (SUM_WIDTH+1)'(err);

    always_comb begin
        if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
            sum_sat = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_wide[SUM_WIDTH-1:0];
        end
    end

    // Next values of both stages and the controller state
    always_comb begin
        in_valid_next  = in_valid_reg;
        adc_next       = adc_reg;
        out_valid_next = out_valid_reg;
        err_next       = err_reg;
        diff_next      = diff_reg;
        sum_next       = sum_reg;
        error_sum_next = error_sum_reg;
        prev_err_next  = prev_err_reg;
        if (adv_in) begin
            in_valid_next = s_valid;
            adc_next      = s_adc_code;
        end
        if (adv_out) begin
            out_valid_next = in_valid_reg;
            err_next       = err;
            diff_next      = DIFF_W'(err) - DIFF_W'(prev_err_reg);
            sum_next       = sum_sat;
            if (in_valid_reg) begin
                error_sum_next = sum_sat;
                prev_err_next  = err;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            error_sum_reg <= '0;
            prev_err_reg  <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            error_sum_reg <= error_sum_next;
            prev_err_reg  <= prev_err_next;
        end
        adc_reg  <= adc_next;
        err_reg  <= err_next;
        diff_reg <= diff_next;
        sum_reg  <= sum_next;
    end

    assign out_valid = out_valid_reg;
    assign out_err   = err_reg;
    assign out_diff  = diff_reg;
    assign out_sum   = sum_reg;

endmodule

[rtl/pidc_product_stage.sv]
// Gain multiplies, then the sum of the three terms.
module pidc_product_stage #(
    parameter int SUM_WIDTH = 32
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic signed [pidc_pkg::ERR_W-1:0]        in_err,
    input  logic signed [pidc_pkg::DIFF_W-1:0]       in_diff,
    input  logic signed [SUM_WIDTH-1:0]              in_sum,
    input  logic signed [pidc_pkg::GAIN_W-1:0]       kp_gain,
    input  logic signed [pidc_pkg::GAIN_W-1:0]       ki_gain,
    input  logic signed [pidc_pkg::GAIN_W-1:0]       kd_gain,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [pidc_pkg::GAIN_W+SUM_WIDTH+1:0] out_total
);
    import pidc_pkg::*;

    localparam int KP_W  = GAIN_W + ERR_W;
    localparam int KI_W  = GAIN_W + SUM_WIDTH;
    localparam int KD_W  = GAIN_W + DIFF_W;
    localparam int TOT_W = GAIN_W + SUM_WIDTH + 2;

    logic                    prod_valid_reg, prod_valid_next;
    logic signed [KP_W-1:0]  kp_prod_reg, kp_prod_next;
    logic signed [KI_W-1:0]  ki_prod_reg, ki_prod_next;
    logic signed [KD_W-1:0]  kd_prod_reg, kd_prod_next;
    logic                    tot_valid_reg, tot_valid_next;
    logic signed [TOT_W-1:0] total_reg, total_next;
    logic                    adv_prod, adv_tot;

    assign adv_tot  = !tot_valid_reg || out_ready;
    assign adv_prod = !prod_valid_reg || adv_tot;
    assign in_ready = adv_prod;

    // Three independent products, then their exact sum
    always_comb begin
        prod_valid_next = prod_valid_reg;
        kp_prod_next    = kp_prod_reg;
        ki_prod_next    = ki_prod_reg;
        kd_prod_next    = kd_prod_reg;
        tot_valid_next  = tot_valid_reg;
        total_next      = total_reg;
        if (adv_prod) begin
            prod_valid_next = in_valid;
            kp_prod_next    = KP_W'(kp_gain) * KP_W'(in_err);
            ki_prod_next    = KI_W'(ki_gain) * KI_W'(in_sum);
            kd_prod_next    = KD_W'(kd_gain) * KD_W'(in_diff);
        end
        if (adv_tot) begin
            tot_valid_next = prod_valid_reg;
            total_next     = TOT_W'(kp_prod_reg) + TOT_W'(ki_prod_reg)
                           + TOT_W'(kd_prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            tot_valid_reg  <= 1'b0;
        end else begin
            prod_valid_reg <= prod_valid_next;
            tot_valid_reg  <= tot_valid_next;
        end
        kp_prod_reg <= kp_prod_next;
        ki_prod_reg <= ki_prod_next;
        kd_prod_reg <= kd_prod_next;
        total_reg   <= total_next;
    end

    assign out_valid = tot_valid_reg;
    assign out_total = total_reg;

endmodule

[rtl/pidc_clamp_stage.sv]
// Scale to Q.16, clamp to the drive bounds, and form the DAC code.
module pidc_clamp_stage #(
    parameter int SUM_WIDTH = 32
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic signed [pidc_pkg::GAIN_W+SUM_WIDTH+1:0] in_total,
    input  logic signed [pidc_pkg::DRIVE_W-1:0]          drive_min,
    input  logic signed [pidc_pkg::DRIVE_W-1:0]          drive_max,
    output logic                                         m_valid,
    input  logic                                         m_ready,
    output logic signed [pidc_pkg::DRIVE_W-1:0]          m_drive_value,
    output logic signed [pidc_pkg::DAC_W-1:0]            m_dac_code,
    output logic                                         m_clamped
);
    import pidc_pkg::*;

    localparam int TOT_W       = GAIN_W + SUM_WIDTH + 2;
    localparam int SHIFT_W     = TOT_W - ADC_BITS;
    localparam int DAC_SCALE_W = $clog2(DAC_FULL_SCALE + 1);
    localparam int DAC_PROD_W  = DRIVE_W + DAC_SCALE_W + 1;
    localparam int QUOT_W      = DAC_PROD_W - FRAC_BITS;
    localparam logic signed [DAC_PROD_W-1:0] FRAC_MASK  = DAC_PROD_W'((1 << FRAC_BITS) - 1);
    localparam logic signed [QUOT_W-1:0]     DAC_LIMIT  = QUOT_W'(DAC_FULL_SCALE);
    localparam logic signed [DAC_PROD_W-1:0] DAC_SCALE  = DAC_PROD_W'(DAC_FULL_SCALE);

    logic                       clip_valid_reg, clip_valid_next;
    logic signed [DRIVE_W-1:0]  drive_reg, drive_next;
    logic                       clip_reg, clip_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [DRIVE_W-1:0]  out_drive_reg, out_drive_next;
    logic signed [DAC_W-1:0]    out_dac_reg, out_dac_next;
    logic                       out_clip_reg, out_clip_next;

    logic                       adv_clip, adv_out;
    logic signed [TOT_W-1:0]    total_shift;
    logic signed [SHIFT_W-1:0]  drive_full;
    logic signed [DRIVE_W-1:0]  drive_lim;
    logic                       lim;
    logic signed [DAC_PROD_W-1:0] scaled;
    logic signed [DAC_PROD_W-1:0] scaled_bias;
    logic signed [QUOT_W-1:0]   quot;
    logic signed [QUOT_W-1:0]   quot_sat;

    assign adv_out  = !out_valid_reg || m_ready;
    assign adv_clip = !clip_valid_reg || adv_out;
    assign in_ready = adv_clip;

    // Floor shift to Q.16, upper bound tested first
    assign total_shift = in_total >>> ADC_BITS;
    assign drive_full  = total_shift[SHIFT_W-1:0];

    always_comb begin
        priority if (drive_full > SHIFT_W'(drive_max)) begin
            drive_lim = drive_max;
            lim       = 1'b1;
        end else if (drive_full < SHIFT_W'(drive_min)) begin
            drive_lim = drive_min;
            lim       = 1'b1;
        end else begin
            drive_lim = drive_full[DRIVE_W-1:0];
            lim       = 1'b0;
        end
    end

    // Scale by full scale, divide by 2^FRAC_BITS toward zero, then saturate
    assign scaled      = DAC_PROD_W'(drive_reg) * DAC_SCALE;
    assign scaled_bias = scaled + (scaled[DAC_PROD_W-1] ? FRAC_MASK : '0);
    assign quot        = QUOT_W'(scaled_bias >>> FRAC_BITS);

    always_comb begin
        priority if (quot > DAC_LIMIT) begin
            quot_sat = DAC_LIMIT;
        end else if (quot < -DAC_LIMIT) begin
            quot_sat = -DAC_LIMIT;
        end else begin
            quot_sat = quot;
        end
    end

    always_comb begin
        clip_valid_next = clip_valid_reg;
        drive_next      = drive_reg;
        clip_next       = clip_reg;
        out_valid_next  = out_valid_reg;
        out_drive_next  = out_drive_reg;
        out_dac_next    = out_dac_reg;
        out_clip_next   = out_clip_reg;
        if (adv_clip) begin
            clip_valid_next = in_valid;
            drive_next      = drive_lim;
            clip_next       = lim;
        end
        if (adv_out) begin
            out_valid_next = clip_valid_reg;
            out_drive_next = drive_reg;
            out_dac_next   = quot_sat[DAC_W-1:0];
            out_clip_next  = clip_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            clip_valid_reg <= clip_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        drive_reg     <= drive_next;
        clip_reg      <= clip_next;
        out_drive_reg <= out_drive_next;
        out_dac_reg   <= out_dac_next;
        out_clip_reg  <= out_clip_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_drive_value = out_drive_reg;
    assign m_dac_code    = out_dac_reg;
    assign m_clamped     = out_clip_reg;

endmodule

[rtl/pid_current_regulator.sv]
// Throughput: one sample per cycle; each of the six pipeline registers moves on
// as soon as the next one is free, so one result waiting on m_ready stalls only
// the stages behind it until they fill.
// Reset (aresetn low, synchronous): pipeline emptied, error sum and last error
// cleared, registers back to their power-on gains, setpoint and bounds.
`include "assert_macros.svh"

module pid_current_regulator #(
    parameter int SUM_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [pidc_pkg::ADC_BITS-1:0]         s_adc_code,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [pidc_pkg::DRIVE_W-1:0]   m_drive_value,
    output logic signed [pidc_pkg::DAC_W-1:0]     m_dac_code,
    output logic                                  m_clamped,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import pidc_pkg::*;

    localparam int TOT_W = GAIN_W + SUM_WIDTH + 2;

    pidc_cfg_t                cfg;
    logic                     err_valid, err_ready;
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SUM_WIDTH-1:0] sum;
    logic                     tot_valid, tot_ready;
    logic signed [TOT_W-1:0]  total;

    // Configuration registers
    pidc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Error and integrator
    pidc_error_stage #(.SUM_WIDTH(SUM_WIDTH)) u_err (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_adc_code    (s_adc_code),
        .setpoint_code (cfg.setpoint_code),
        .out_valid     (err_valid),
        .out_ready     (err_ready),
        .out_err       (err),
        .out_diff      (diff),
        .out_sum       (sum)
    );

    // Gain products and their sum
    pidc_product_stage #(.SUM_WIDTH(SUM_WIDTH)) u_prod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (err_valid),
        .in_ready  (err_ready),
        .in_err    (err),
        .in_diff   (diff),
        .in_sum    (sum),
        .kp_gain   (cfg.kp_gain),
        .ki_gain   (cfg.ki_gain),
        .kd_gain   (cfg.kd_gain),
        .out_valid (tot_valid),
        .out_ready (tot_ready),
        .out_total (total)
    );

    // Clamp and DAC code
    pidc_clamp_stage #(.SUM_WIDTH(SUM_WIDTH)) u_clamp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (tot_valid),
        .in_ready      (tot_ready),
        .in_total      (total),
        .drive_min     (cfg.drive_min),
        .drive_max     (cfg.drive_max),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_drive_value (m_drive_value),
        .m_dac_code    (m_dac_code),
        .m_clamped     (m_clamped)
    );

    // An empty output register lets every stage advance
    `ASSERT_IMPLIES(a_ready_when_out_empty, aclk, aresetn, !m_valid, s_ready)
    // The DAC code never leaves the full-scale range
    `ASSERT_IMPLIES(a_dac_in_range, aclk, aresetn, m_valid, (m_dac_code <= DAC_W'(DAC_FULL_SCALE)) && (m_dac_code >= -(DAC_W'(DAC_FULL_SCALE))))
    // A non-negative drive gives a non-negative DAC code
    `ASSERT_IMPLIES(a_dac_sign, aclk, aresetn, m_valid && !m_drive_value[DRIVE_W-1], !m_dac_code[DAC_W-1])
    // A proportional gain write lands in the register
    `ASSERT_NEXT(a_kp_write, aclk, aresetn, cfg_valid && cfg_ready && (cfg_index == REG_KP_GAIN), cfg.kp_gain == $past(cfg_data[GAIN_W-1:0]))

endmodule

[test/pidc_drive_checker.sv]
// Checker for the PID current regulator: tracks register writes, predicts each drive result.
module pidc_drive_checker
    import pidc_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [ADC_BITS-1:0]          s_adc_code,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic signed [DRIVE_W-1:0]    m_drive_value,
    input  logic signed [DAC_W-1:0]      m_dac_code,
    input  logic                         m_clamped,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    output int                           fail_count,
    output int                           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive_value;
        logic signed [DAC_W-1:0]   dac_code;
        logic                      clamped;
    } drive_result_t;

    localparam longint SUM_MAX = (64'sd1 <<< 31) - 64'sd1;
    localparam longint SUM_MIN = -SUM_MAX - 64'sd1;

    // Shadow copy of the register file and the integrator state
    logic [ADC_BITS-1:0] setpoint;
    longint              kp;
    longint              ki;
    longint              kd;
    longint              drive_lo;
    longint              drive_hi;
    longint              err_sum;
    longint              last_err;

    drive_result_t drive_q[$];

    // Advance the integrator by one sample and return the drive it produces
    function automatic drive_result_t compute_drive(input logic [ADC_BITS-1:0] code);
        longint        err;
        longint        total;
        longint        drive;
        longint        dac;
        drive_result_t r;
        err = longint'(setpoint) - longint'(code);
        err_sum = err_sum + err;
        if (err_sum > SUM_MAX) err_sum = SUM_MAX;
        if (err_sum < SUM_MIN) err_sum = SUM_MIN;
        total = kp * err + ki * err_sum + kd * (err - last_err);
        last_err = err;

        // Floor shift to Q.16, then clamp with the upper bound taking priority
        drive = total >>> ADC_BITS;
        r.clamped = 1'b0;
        if (drive > drive_hi) begin
            drive = drive_hi;
            r.clamped = 1'b1;
        end else if (drive < drive_lo) begin
            drive = drive_lo;
            r.clamped = 1'b1;
        end

        // Scale to DAC codes, truncating toward zero, and hold within full scale
        dac = (drive * longint'(DAC_FULL_SCALE)) / (64'sd1 <<< FRAC_BITS);
        if (dac > longint'(DAC_FULL_SCALE)) dac = longint'(DAC_FULL_SCALE);
        if (dac < -longint'(DAC_FULL_SCALE)) dac = -longint'(DAC_FULL_SCALE);

        r.drive_value = drive[DRIVE_W-1:0];
        r.dac_code    = dac[DAC_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        drive_result_t want;
        if (!aresetn) begin
            setpoint   = SETPOINT_RESET;
            kp         = longint'(KP_RESET);
            ki         = longint'(KI_RESET);
            kd         = longint'(KD_RESET);
            drive_lo   = longint'(DRIVE_MIN_RESET);
            drive_hi   = longint'(DRIVE_MAX_RESET);
            err_sum    = 0;
            last_err   = 0;
            fail_count = 0;
            drive_q.delete();
        end else begin
            // Mirror register writes; unknown indexes are dropped
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SETPOINT:  setpoint = cfg_data[ADC_BITS-1:0];
                    REG_KP_GAIN:   kp       = longint'($signed(cfg_data[GAIN_W-1:0]));
                    REG_KI_GAIN:   ki       = longint'($signed(cfg_data[GAIN_W-1:0]));
                    REG_KD_GAIN:   kd       = longint'($signed(cfg_data[GAIN_W-1:0]));
                    REG_DRIVE_MIN: drive_lo = longint'($signed(cfg_data[DRIVE_W-1:0]));
                    REG_DRIVE_MAX: drive_hi = longint'($signed(cfg_data[DRIVE_W-1:0]));
                    default: ;
                endcase
            end

            // Compare each result transfer against the oldest prediction
            if (m_valid && m_ready) begin
                if (drive_q.size() == 0) begin
                    $error("result transfer with no sample outstanding");
                    fail_count++;
                end else begin
                    want = drive_q.pop_front();
                    if (m_drive_value !== want.drive_value) begin
                        $error("drive_value: expected %0d, got %0d",
                               want.drive_value, m_drive_value);
                        fail_count++;
                    end
                    if (m_dac_code !== want.dac_code) begin
                        $error("dac_code: expected %0d, got %0d", want.dac_code, m_dac_code);
                        fail_count++;
                    end
                    if (m_clamped !== want.clamped) begin
                        $error("clamped: expected %0d, got %0d", want.clamped, m_clamped);
                        fail_count++;
                    end
                end
            end

            if (s_valid && s_ready) drive_q.push_back(compute_drive(s_adc_code));
        end
        pending = drive_q.size();
    end

endmodule

[test/tb_pid_current_regulator.sv]
// Testbench top for the PID current regulator: stimulus, flow control and verdict.
module tb_pid_current_regulator;
    timeunit 1ns;
    timeprecision 1ps;

    import pidc_pkg::*;

    localparam int CYCLE_LIMIT    = 200_000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int PHASE_ITEMS    = 115;
    localparam int SATURATE_ITEMS = 20;
    localparam int SAT_GAIN       = 524_416;

    // Indexes past the register list; writes there must have no effect
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                        aclk       = 1'b0;
    logic                        aresetn    = 1'b0;
    logic                        s_valid    = 1'b0;
    logic                        s_ready;
    logic [ADC_BITS-1:0]         s_adc_code = '0;
    logic                        m_valid;
    logic                        m_ready    = 1'b0;
    logic signed [DRIVE_W-1:0]   m_drive_value;
    logic signed [DAC_W-1:0]     m_dac_code;
    logic                        m_clamped;
    logic                        cfg_valid  = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index  = '0;
    logic [CFG_DATA_W-1:0]       cfg_data   = '0;

    int                  fail_count;
    int                  pending;
    int                  idle_pct     = 10;
    int                  stall_pct    = 61;
    int                  cycle_count  = 0;
    logic [ADC_BITS-1:0] cur_setpoint = SETPOINT_RESET;

    always #5ns aclk = ~aclk;

    pid_current_regulator u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_adc_code    (s_adc_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_drive_value (m_drive_value),
        .m_dac_code    (m_dac_code),
        .m_clamped     (m_clamped),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    pidc_drive_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_adc_code    (s_adc_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_drive_value (m_drive_value),
        .m_dac_code    (m_dac_code),
        .m_clamped     (m_clamped),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Random backpressure on the result channel
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offer one sample, with an optional random gap first, and hold until transfer
    task automatic send_sample(input logic [ADC_BITS-1:0] code);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_adc_code <= code;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_gains(input logic [CFG_DATA_W-1:0] sp, input logic [CFG_DATA_W-1:0] kp,
                              input logic [CFG_DATA_W-1:0] ki, input logic [CFG_DATA_W-1:0] kd,
                              input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi);
        write_reg(REG_SETPOINT, sp);
        write_reg(REG_KP_GAIN, kp);
        write_reg(REG_KI_GAIN, ki);
        write_reg(REG_KD_GAIN, kd);
        write_reg(REG_DRIVE_MIN, lo);
        write_reg(REG_DRIVE_MAX, hi);
        cur_setpoint = sp[ADC_BITS-1:0];
    endtask

    // Drop valid and wait until every predicted result has been taken
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Gain with a random magnitude scale, so small and large gains both show up
    function automatic logic [CFG_DATA_W-1:0] rand_gain();
        int unsigned sh;
        logic [31:0] v;
        sh = $urandom_range(GAIN_W - 1);
        v = $urandom & ((32'd1 << sh) - 32'd1);
        if ($urandom_range(1) == 1) v = -v;
        return v[CFG_DATA_W-1:0];
    endfunction

    // Mostly samples close to the setpoint, sometimes anywhere in range
    function automatic logic [ADC_BITS-1:0] pick_sample(input logic [ADC_BITS-1:0] center);
        int v;
        if ($urandom_range(9) < 7) v = int'(center) + int'($urandom_range(128)) - 64;
        else v = int'($urandom_range(4095));
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[ADC_BITS-1:0];
    endfunction

    initial begin
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [CFG_DATA_W-1:0] sp;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Power-on registers: both code extremes and alternating bit patterns
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd696);
        send_sample(12'd696);
        send_sample(12'hAAA);
        send_sample(12'h555);
        send_sample(12'd4094);
        send_sample(12'd1);
        settle();

        // Largest gains with the full-scale bounds
        load_gains(24'd4095, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'(-65536), 24'd65536);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd4095);
        settle();

        // Most negative gains; bounds past full scale force the DAC code to saturate
        load_gains(24'd0, 24'h800000, 24'h800000, 24'h800000, 24'h020000, 24'h01FFFF);
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd0);
        settle();

        // Crossed bounds, then writes to indexes beyond the register list
        load_gains(24'd2048, 24'd65536, 24'd0, 24'd0, 24'd1000, 24'(-1000));
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd2048);
        settle();
        write_reg(REG_SPARE_A, 24'($urandom));
        write_reg(REG_SPARE_B, 24'($urandom));
        send_sample(12'd2048);
        send_sample(12'd100);

        // Random settings; flow control moves from receiver stalls to sender idling to none
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            idle_pct  = (ph < 2) ? 10 : (ph < 4) ? 61 : 0;
            stall_pct = (ph < 2) ? 61 : (ph < 4) ? 10 : 0;
            lo = 24'($urandom);
            hi = 24'($urandom);
            case ($urandom_range(9))
                0: begin
                    lo[DRIVE_W-1:0] = 18'($urandom_range(5000));
                    hi[DRIVE_W-1:0] = 18'(-int'($urandom_range(5000)));
                end
                1: ;
                default: begin
                    lo[DRIVE_W-1:0] = 18'(-int'($urandom_range(65536)));
                    hi[DRIVE_W-1:0] = 18'($urandom_range(65536));
                end
            endcase
            sp = 24'($urandom);
            load_gains(sp, rand_gain(), rand_gain(), rand_gain(), lo, hi);
            for (int n = 0; n < PHASE_ITEMS; n++) send_sample(pick_sample(cur_setpoint));
        end

        // Hold the largest error so the integrator climbs while kp pulls the other way
        settle();
        idle_pct  = 0;
        stall_pct = 0;
        load_gains(24'd4095, 24'(-SAT_GAIN), 24'd1, 24'd0, 24'(-65536), 24'd65536);
        for (int n = 0; n < SATURATE_ITEMS; n++) send_sample(12'd0);

        // Reverse the error and walk the integrator back down
        settle();
        load_gains(24'd0, 24'(SAT_GAIN), 24'd1, 24'd0, 24'(-65536), 24'd65536);
        for (int n = 0; n < 20; n++) send_sample(12'd4095);

        settle();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/pidc_pkg.sv
rtl/pidc_cfg_regs.sv
rtl/pidc_error_stage.sv
rtl/pidc_product_stage.sv
rtl/pidc_clamp_stage.sv
rtl/pid_current_regulator.sv
test/pidc_drive_checker.sv
test/tb_pid_current_regulator.sv
